// ===== rtl/core/cmsp_pkg.sv =====
// Shared types, constants and the quarter-sine table generator for the cross-modulated sine pair.
package cmsp_pkg;

    // Stream payload widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 40;

    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

    localparam cfg_index_t REG_MOD_KIND     = 1'b0;
    localparam cfg_index_t REG_PHASE_PER_HZ = 1'b1;

    // Modulation kinds.
    localparam logic MOD_FM = 1'b0;
    localparam logic MOD_PM = 1'b1;

    localparam logic [39:0] PHASE_PER_HZ_RESET = 40'd5864062014;

    // One channel's oscillator state as kept in the state memory.
    typedef struct packed {
        logic [31:0]        phase_one;
        logic [31:0]        phase_two;
        logic signed [15:0] feedback;
    } chan_state_t;

    // pi in Q30.
    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // One entry of the quarter-wave table: 32767 * sin at the center of bin idx,
    // evaluated with a Q30 Taylor series through the x^15 term.
    function automatic logic [15:0] sine_entry(int unsigned idx, int unsigned tbits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        int unsigned     n;
        x    = (PI_Q30 * 64'(2 * idx + 1)) >> (tbits + 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) != 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        sum = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (sum > 32767) begin
            sum = 32767;
        end
        return 16'(sum);
    endfunction

endpackage

// ===== rtl/core/cmsp_sine_rom.sv =====
// Quarter-wave sine lookup with quadrant folding and a registered read.
module cmsp_sine_rom #(
    parameter int TABLE_BITS = 9
) (
    input  logic               aclk,
    input  logic               rd_en,
    input  logic [31:0]        phase,
    output logic signed [15:0] sample
);
    import cmsp_pkg::*;

    localparam int TBL_SIZE = 1 << TABLE_BITS;

    typedef logic [15:0] rom_t [TBL_SIZE];

    function automatic rom_t make_rom();
        rom_t r;
        for (int i = 0; i < TBL_SIZE; i++) begin
            r[i] = sine_entry(i, TABLE_BITS);
        end
        return r;
    endfunction

    localparam rom_t ROM = make_rom();

    logic [TABLE_BITS-1:0] addr;
    logic [15:0]           rom_q_reg;
    logic                  neg_reg;

    // Odd quadrants walk the table backwards.
    assign addr = phase[29 -: TABLE_BITS] ^ {TABLE_BITS{phase[30]}};

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rom_q_reg <= ROM[addr];
            neg_reg   <= phase[31];
        end
    end

    // The second half of the cycle is the negated first half.
    assign sample = neg_reg ? (16'd0 - rom_q_reg) : rom_q_reg;

endmodule

// ===== rtl/core/cross_modulated_sine_pair_top.sv =====
// Top level of the cross-modulated sine pair: stream ports, state memory and sequencer.
//
// Each request on the input stream is one sample for one channel's pair of sine
// oscillators; oscillator one is modulated by the stored previous output of
// oscillator two, and oscillator two by the fresh output of oscillator one, either
// in phase (modulation_kind = 1) or in frequency (modulation_kind = 0). Every
// request yields exactly one result. The block handles one request at a time: after
// accepting a request it runs ten sequencer steps before it takes the next one, a
// sequence set by the single shared 34 x 21 bit multiplier, which is used
// six times per request, and by the two dependent reads of the sine table, each
// through a registered read. The next request may be accepted while the previous
// result still waits in the output register; the block only stalls at its last
// step if that register is still full. Per-channel phases and feedback samples
// live in a small synchronous memory that reads as zero until a channel is first
// used after reset, so no clearing pass is needed. A channel number at or above
// CHANNELS folds onto channel modulo CHANNELS, while the result still echoes the
// original number. Configuration must only be written while the block is idle.
module cross_modulated_sine_pair_top #(
    parameter int CHANNELS   = 8,
    parameter int TABLE_BITS = 9
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  cmsp_pkg::cfg_index_t                cfg_addr,
    input  cmsp_pkg::cfg_data_t                 cfg_wdata,
    // Input stream.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, lowest bit up: channel[2:0], freq_one[34:3], depth_one[66:35],
    // freq_two[98:67], depth_two[130:99], zero pad[135:131].
    input  logic [cmsp_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, lowest bit up: out_channel[2:0], sample_one[18:3],
    // sample_two[34:19], zero pad[39:35].
    output logic [cmsp_pkg::M_TDATA_W-1:0]      m_tdata
);
    import cmsp_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Folding of the 3-bit channel number onto the implemented channels.
    typedef logic [CW-1:0] chmap_t [8];

    function automatic chmap_t make_chmap();
        chmap_t m;
        for (int i = 0; i < 8; i++) begin
            m[i] = CW'(i % CHANNELS);
        end
        return m;
    endfunction

    localparam chmap_t CH_MAP = make_chmap();

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MOD1,
        ST_SIN1,
        ST_WAIT1,
        ST_MOD2,
        ST_SIN2,
        ST_WAIT2,
        ST_INC2H,
        ST_FIN1,
        ST_STORE
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic        kind_reg;
    logic [39:0] pph_reg;

    // Request fields.
    logic [2:0]         chan_reg;
    logic [CW-1:0]      cidx_reg;
    logic signed [31:0] f1_reg;
    logic signed [31:0] d1_reg;
    logic signed [31:0] f2_reg;
    logic signed [31:0] d2_reg;

    // Working state for the channel.
    logic [31:0]        ph1_reg;
    logic [31:0]        ph2_reg;
    logic signed [15:0] fb_reg;
    logic signed [15:0] s1_reg;
    logic signed [15:0] s2_reg;
    logic signed [33:0] hz1_reg;
    logic signed [33:0] hz2_reg;
    logic signed [63:0] acc_reg;
    logic [31:0]        inc1_reg;
    logic [31:0]        inc2_reg;

    // Shared multiplier.
    logic signed [33:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [54:0] prod_reg;

    // State memory.
    chan_state_t        mem [CHANNELS];
    chan_state_t        mem_q_reg;
    logic               vld_q_reg;
    logic [CHANNELS-1:0] vld_reg;
    logic               mem_rd;
    logic               mem_we;
    logic [CW-1:0]      rd_idx;
    chan_state_t        mem_wdata;

    // Output register.
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_free;

    // Sine table interface.
    logic               sin_rd;
    logic [31:0]        sin_phase;
    logic signed [15:0] sin_sample;

    logic               s_accept;
    logic [31:0]        pm_off;
    logic signed [33:0] fm_hz;
    logic signed [63:0] inc_sum;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign rd_idx = CH_MAP[s_tdata[2:0]];
    assign mem_rd = s_accept;
    assign mem_we = (state_reg == ST_STORE) && out_free;

    assign mem_wdata.phase_one = ph1_reg;
    assign mem_wdata.phase_two = ph2_reg + inc2_reg;
    assign mem_wdata.feedback  = s2_reg;

    // The product in prod_reg is sample * depth when it feeds the modulation.
    // In phase mode it is cycles times 2^31; in frequency mode it is Hz times 2^15.
    assign pm_off = {prod_reg[30:0], 1'b0};

    always_comb begin
        if (state_reg == ST_SIN1) begin
            fm_hz = 34'(f1_reg) + 34'($signed(prod_reg[47:15]));
        end else begin
            fm_hz = 34'(f2_reg) + 34'($signed(prod_reg[47:15]));
        end
    end

    // Phase increment: bits 63..32 of hz * phase_per_hz, built from the low and the
    // high 20-bit halves of phase_per_hz.
    assign inc_sum = acc_reg + (64'(prod_reg) <<< 20);

    // Sine reads are issued with the modulated phase in phase mode.
    always_comb begin
        sin_rd    = 1'b0;
        sin_phase = ph1_reg;
        case (state_reg)
            ST_SIN1: begin
                sin_rd    = 1'b1;
                sin_phase = (kind_reg == MOD_PM) ? (ph1_reg + pm_off) : ph1_reg;
            end
            ST_SIN2: begin
                sin_rd    = 1'b1;
                sin_phase = (kind_reg == MOD_PM) ? (ph2_reg + pm_off) : ph2_reg;
            end
            default: begin
                sin_rd    = 1'b0;
                sin_phase = ph1_reg;
            end
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_MOD1: begin
                mul_a = 34'(d2_reg);
                mul_b = 21'(fb_reg);
            end
            ST_WAIT1: begin
                mul_a = hz1_reg;
                mul_b = {1'b0, pph_reg[19:0]};
            end
            ST_MOD2: begin
                mul_a = 34'(d1_reg);
                mul_b = 21'(s1_reg);
            end
            ST_SIN2: begin
                mul_a = hz1_reg;
                mul_b = {1'b0, pph_reg[39:20]};
            end
            ST_WAIT2: begin
                mul_a = hz2_reg;
                mul_b = {1'b0, pph_reg[19:0]};
            end
            ST_INC2H: begin
                mul_a = hz2_reg;
                mul_b = {1'b0, pph_reg[39:20]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    cmsp_sine_rom #(
        .TABLE_BITS(TABLE_BITS)
    ) u_sine (
        .aclk   (aclk),
        .rd_en  (sin_rd),
        .phase  (sin_phase),
        .sample (sin_sample)
    );

    // State memory: read at acceptance, written back once at the last step.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cidx_reg] <= mem_wdata;
        end
        if (mem_rd) begin
            mem_q_reg <= mem[rd_idx];
        end
    end

    // A channel that was never written reads as the reset state of zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (mem_we) begin
                vld_reg[cidx_reg] <= 1'b1;
            end
            if (mem_rd) begin
                vld_q_reg <= vld_reg[rd_idx];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= MOD_FM;
            pph_reg  <= PHASE_PER_HZ_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MOD_KIND:     kind_reg <= cfg_wdata[0];
                REG_PHASE_PER_HZ: pph_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Sequencer with its datapath and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A result taken in the same cycle as a new one is stored stays valid.
            if (m_tvalid_reg && m_tready && !mem_we) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        chan_reg  <= s_tdata[2:0];
                        cidx_reg  <= rd_idx;
                        f1_reg    <= s_tdata[34:3];
                        d1_reg    <= s_tdata[66:35];
                        f2_reg    <= s_tdata[98:67];
                        d2_reg    <= s_tdata[130:99];
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    ph1_reg   <= vld_q_reg ? mem_q_reg.phase_one : '0;
                    ph2_reg   <= vld_q_reg ? mem_q_reg.phase_two : '0;
                    fb_reg    <= vld_q_reg ? mem_q_reg.feedback : '0;
                    state_reg <= ST_MOD1;
                end
                ST_MOD1: begin
                    state_reg <= ST_SIN1;
                end
                ST_SIN1: begin
                    hz1_reg   <= (kind_reg == MOD_PM) ? 34'(f1_reg) : fm_hz;
                    state_reg <= ST_WAIT1;
                end
                ST_WAIT1: begin
                    s1_reg    <= sin_sample;
                    state_reg <= ST_MOD2;
                end
                ST_MOD2: begin
                    acc_reg   <= 64'(prod_reg);
                    state_reg <= ST_SIN2;
                end
                ST_SIN2: begin
                    hz2_reg   <= (kind_reg == MOD_PM) ? 34'(f2_reg) : fm_hz;
                    state_reg <= ST_WAIT2;
                end
                ST_WAIT2: begin
                    s2_reg    <= sin_sample;
                    inc1_reg  <= inc_sum[63:32];
                    state_reg <= ST_INC2H;
                end
                ST_INC2H: begin
                    acc_reg   <= 64'(prod_reg);
                    ph1_reg   <= ph1_reg + inc1_reg;
                    state_reg <= ST_FIN1;
                end
                ST_FIN1: begin
                    inc2_reg  <= inc_sum[63:32];
                    state_reg <= ST_STORE;
                end
                ST_STORE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0, s2_reg, s1_reg, chan_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_LOAD))
        else $error("accepted request did not start the sequencer");

    a_store_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> m_tvalid_reg)
        else $error("state write-back without a result");

    a_result_from_store: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_STORE))
        else $error("result raised outside the last sequencer step");

    a_no_mem_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_rd && mem_we))
        else $error("state memory read and written in the same cycle");
`endif

endmodule
